// ===== rtl/core/dts_pkg.sv =====
// Shared types, constants and the suffix decoder for the duration text parser.
package dts_pkg;

    localparam int DEFAULT_RESULT_BITS = 31;
    localparam int SECONDS_W = 31;
    localparam int WEIGHT_W = 17;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_PARSE = 2'd1;
    localparam logic [1:0] STATUS_RANGE = 2'd2;

    localparam logic [1:0] SLOT_DAY    = 2'd0;
    localparam logic [1:0] SLOT_HOUR   = 2'd1;
    localparam logic [1:0] SLOT_MINUTE = 2'd2;
    localparam logic [1:0] SLOT_SECOND = 2'd3;

    localparam logic [WEIGHT_W-1:0] DAY_SECONDS    = 17'd86400;
    localparam logic [WEIGHT_W-1:0] HOUR_SECONDS   = 17'd3600;
    localparam logic [WEIGHT_W-1:0] MINUTE_SECONDS = 17'd60;
    localparam logic [WEIGHT_W-1:0] SECOND_SECONDS = 17'd1;

    typedef struct packed {
        logic [7:0] character;
        logic       end_of_text;
    } text_beat_t;

    typedef struct packed {
        logic [SECONDS_W-1:0] seconds;
        logic [1:0]           status;
    } result_beat_t;

    typedef struct packed {
        logic       valid;
        logic [1:0] slot;
    } suffix_t;

    function automatic suffix_t decode_suffix(input logic [7:0] c);
        suffix_t s;
        s.valid = 1'b1;
        s.slot  = SLOT_DAY;
        case (c)
            "d", "D": s.slot = SLOT_DAY;
            "h", "H": s.slot = SLOT_HOUR;
            "m", "M": s.slot = SLOT_MINUTE;
            "s", "S": s.slot = SLOT_SECOND;
            default:  s.valid = 1'b0;
        endcase
        return s;
    endfunction

endpackage

// ===== rtl/core/duration_text_to_seconds.sv =====
// Top level of the duration text parser: input register, per-character logic, result register.
//
// The block takes one character beat per cycle and answers each end-of-text beat with one
// result beat giving the total seconds and a status. An end beat waits in the input register
// until the output is free and its result is then registered in the result register.
// Throughput is one beat per cycle, set by the times-ten-plus-digit update of the run value;
// the weighted value of a finished run is added to the total during the following beat. The
// input stalls only while an end beat waits for a result beat that has not yet been taken.
module duration_text_to_seconds #(
    parameter int RESULT_BITS = dts_pkg::DEFAULT_RESULT_BITS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 text_valid,
    output logic                 text_ready,
    input  dts_pkg::text_beat_t  text,
    output logic                 result_valid,
    input  logic                 result_ready,
    output dts_pkg::result_beat_t result
);
    import dts_pkg::*;

    localparam int RB = RESULT_BITS;
    localparam int NUM_W = RB + 4;
    localparam int PROD_W = RB + WEIGHT_W;
    localparam logic [63:0] LIMIT64 = (64'd1 << RESULT_BITS) - 64'd1;
    localparam logic [RB-1:0] DAY_MAX    = RB'(LIMIT64 / DAY_SECONDS);
    localparam logic [RB-1:0] HOUR_MAX   = RB'(LIMIT64 / HOUR_SECONDS);
    localparam logic [RB-1:0] MINUTE_MAX = RB'(LIMIT64 / MINUTE_SECONDS);
    localparam logic [RB-1:0] SECOND_MAX = RB'(LIMIT64 / SECOND_SECONDS);

    logic         in_valid_reg;
    text_beat_t   in_beat_reg;

    logic [RB-1:0] cur_reg, cur_next;
    logic          too_big_reg, too_big_next;
    logic          pending_reg, pending_next;
    logic [1:0]    slot_reg, slot_next;
    logic [RB-1:0] total_reg, total_next;
    logic [1:0]    error_reg, error_next;
    logic          add_valid_reg, add_valid_next;
    logic [RB-1:0] add_value_reg, add_value_next;
    logic          result_valid_reg, result_valid_next;
    result_beat_t  result_reg, result_next;

    logic                advance;
    logic [7:0]          c;
    logic                is_digit;
    logic [RB-1:0]       addend;
    logic [RB:0]         sum;
    logic                sum_over;
    logic [1:0]          error_eff;
    logic [RB-1:0]       total_eff;
    logic [NUM_W-1:0]    scaled;
    logic                scaled_over;
    suffix_t             suffix;
    logic [WEIGHT_W-1:0] weight;
    logic [RB-1:0]       weight_max;
    logic [PROD_W-1:0]   product;
    logic [1:0]          end_status;
    logic [RB-1:0]       end_total;

    assign advance = in_valid_reg
                     && (!in_beat_reg.end_of_text || !result_valid_reg || result_ready);
    assign text_ready = !in_valid_reg || advance;
    assign result_valid = result_valid_reg;
    assign result = result_reg;

    assign c = in_beat_reg.character;
    assign is_digit = (c >= "0") && (c <= "9");

    // A finished run waits one beat in the add register; otherwise the end beat adds the
    // unsuffixed run, which counts as seconds.
    assign addend = add_valid_reg ? add_value_reg : cur_reg;
    assign sum = {1'b0, total_reg} + {1'b0, addend};
    assign sum_over = sum[RB];
    assign error_eff = (add_valid_reg && sum_over) ? STATUS_RANGE : error_reg;
    assign total_eff = (add_valid_reg && !sum_over) ? sum[RB-1:0] : total_reg;

    assign scaled = ({4'b0, cur_reg} << 3) + ({4'b0, cur_reg} << 1) + NUM_W'(c[3:0]);
    assign scaled_over = |scaled[NUM_W-1:RB];

    assign suffix = decode_suffix(c);

    always_comb
    begin
        case (suffix.slot)
            SLOT_DAY:
            begin
                weight = DAY_SECONDS;
                weight_max = DAY_MAX;
            end
            SLOT_HOUR:
            begin
                weight = HOUR_SECONDS;
                weight_max = HOUR_MAX;
            end
            SLOT_MINUTE:
            begin
                weight = MINUTE_SECONDS;
                weight_max = MINUTE_MAX;
            end
            default:
            begin
                weight = SECOND_SECONDS;
                weight_max = SECOND_MAX;
            end
        endcase
    end

    assign product = {{WEIGHT_W{1'b0}}, cur_reg} * {{RB{1'b0}}, weight};

    always_comb
    begin
        end_status = error_eff;
        end_total = total_eff;
        if (error_eff == STATUS_OK && pending_reg)
        begin
            if (too_big_reg || sum_over)
            begin
                end_status = STATUS_RANGE;
            end
            else
            begin
                end_total = sum[RB-1:0];
            end
        end
    end

    always_comb
    begin
        cur_next = cur_reg;
        too_big_next = too_big_reg;
        pending_next = pending_reg;
        slot_next = slot_reg;
        total_next = total_reg;
        error_next = error_reg;
        add_valid_next = add_valid_reg;
        add_value_next = add_value_reg;
        result_valid_next = result_valid_reg && !result_ready;
        result_next = result_reg;
        if (advance)
        begin
            add_valid_next = 1'b0;
            error_next = error_eff;
            total_next = total_eff;
            if (in_beat_reg.end_of_text)
            begin
                result_valid_next = 1'b1;
                result_next.status = end_status;
                result_next.seconds = (end_status == STATUS_OK) ? SECONDS_W'(end_total) : '0;
                cur_next = '0;
                too_big_next = 1'b0;
                pending_next = 1'b0;
                slot_next = SLOT_DAY;
                total_next = '0;
                error_next = STATUS_OK;
            end
            else if (error_eff == STATUS_OK)
            begin
                if (is_digit)
                begin
                    pending_next = 1'b1;
                    if (!too_big_reg)
                    begin
                        if (scaled_over)
                        begin
                            too_big_next = 1'b1;
                        end
                        else
                        begin
                            cur_next = scaled[RB-1:0];
                        end
                    end
                end
                else if (!pending_reg)
                begin
                    error_next = STATUS_PARSE;
                end
                else
                begin
                    if (!suffix.valid || suffix.slot < slot_reg)
                    begin
                        error_next = STATUS_PARSE;
                    end
                    else
                    begin
                        slot_next = suffix.slot;
                        if (too_big_reg || cur_reg > weight_max)
                        begin
                            error_next = STATUS_RANGE;
                        end
                        else
                        begin
                            add_valid_next = 1'b1;
                            add_value_next = product[RB-1:0];
                        end
                    end
                    cur_next = '0;
                    too_big_next = 1'b0;
                    pending_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            cur_reg <= '0;
            too_big_reg <= 1'b0;
            pending_reg <= 1'b0;
            slot_reg <= SLOT_DAY;
            total_reg <= '0;
            error_reg <= STATUS_OK;
            add_valid_reg <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (text_ready)
            begin
                in_valid_reg <= text_valid;
            end
            cur_reg <= cur_next;
            too_big_reg <= too_big_next;
            pending_reg <= pending_next;
            slot_reg <= slot_next;
            total_reg <= total_next;
            error_reg <= error_next;
            add_valid_reg <= add_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (text_ready && text_valid)
        begin
            in_beat_reg <= text;
        end
        add_value_reg <= add_value_next;
        result_reg <= result_next;
    end

endmodule

// ===== rtl/core/dts_checker.sv =====
// Port-level assertions for the duration text parser and the bind that attaches them.
module dts_checker (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  text_valid,
    input logic                  text_ready,
    input logic                  result_valid,
    input logic                  result_ready,
    input dts_pkg::result_beat_t result
);
    import dts_pkg::*;

    // A stalled result beat must hold.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result beat changed while stalled");

    // Any failing status carries zero seconds.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.status != STATUS_OK |-> result.seconds == '0)
        else $error("nonzero seconds with error status");

    // With no result waiting, the input never stalls.
    assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> text_ready)
        else $error("input stalled with empty output");

    // Once the output is drained, the input is taken in the same cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_ready |-> text_ready)
        else $error("input stalled while output is taken");

endmodule

bind duration_text_to_seconds dts_checker u_dts_checker (.*);
